// ===== rtl/tcc_pkg.sv =====
package tcc_pkg;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned WIN_W   = 16;
  localparam int unsigned BIN_W   = 16;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned S_TDATA_W = CODE_W + TIME_W;
  localparam int unsigned M_TDATA_W = BIN_W + 3 * CNT_W;

  localparam logic [WIN_W-1:0]  WINDOW_RESET  = 16'd208;
  localparam logic [BIN_W-1:0]  PER_BIN_RESET = 16'd680;
  localparam logic [TIME_W-1:0] BASE_RESET    = 32'h8000_0000;

  // valid detector hit codes
  localparam logic [CODE_W-1:0] CODE_A = 8'd1;
  localparam logic [CODE_W-1:0] CODE_B = 8'd3;
  localparam logic [CODE_W-1:0] CODE_C = 8'd4;
  localparam logic [CODE_W-1:0] CODE_D = 8'd12;
  localparam logic [CODE_W-1:0] CODE_E = 8'd16;
  localparam logic [CODE_W-1:0] CODE_F = 8'd48;

  typedef enum logic [1:0] {
    REG_WINDOW  = 2'd0,
    REG_PER_BIN = 2'd1,
    REG_BASE    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] ts;
  } rec_t;

  function automatic logic code_ok(input logic [CODE_W-1:0] c);
    return (c == CODE_A) || (c == CODE_B) || (c == CODE_C) ||
           (c == CODE_D) || (c == CODE_E) || (c == CODE_F);
  endfunction

  // t <= base + win, taken one bit wider so it cannot wrap
  function automatic logic near_enough(input logic [TIME_W-1:0] t,
                                       input logic [TIME_W-1:0] base,
                                       input logic [WIN_W-1:0]  win);
    logic [TIME_W:0] lim;
    lim = {1'b0, base} + {{(TIME_W+1-WIN_W){1'b0}}, win};
    return {1'b0, t} <= lim;
  endfunction

endpackage

// ===== rtl/triple_coincidence_counter.sv =====
// Channel    Dir  Handshake                 Payload
// s_axis     in   s_axis_tvalid/tready      tdata: event_code, timestamp
// m_axis     out  m_axis_tvalid/tready      tdata: bin_index, triples_in_bin,
//                                                  total_triples, total_markers
// apb        in   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One word per cycle: every accepted word is judged in the cycle it is taken,
// against the two oldest window entries held in registers, so the rate is
// one word per clock. A result appears on m_axis in the cycle after the word
// that completes a bin. The result register frees s_axis_tready as soon as
// it is empty or being drained; only a held, untaken result stalls input.
// rst (synchronous, active high) disarms and resets all but window/result data.
module triple_coincidence_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] event_code, [39:8] timestamp
  input  logic [tcc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] bin_index, [47:16] triples_in_bin, [79:48] total_triples,
  // [111:80] total_markers
  output logic [tcc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcc_pkg::ADDR_W-1:0]    paddr,
  input  logic [tcc_pkg::DATA_W-1:0]    pwdata,
  output logic [tcc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import tcc_pkg::*;

  // configuration registers
  logic [WIN_W-1:0]  coincidence_window;
  logic [BIN_W-1:0]  markers_per_bin;
  logic [TIME_W-1:0] marker_base;

  // block state
  logic              armed;
  rec_t              win0, win1;     // oldest and second-oldest records
  logic [1:0]        fill;
  logic [TIME_W-1:0] expected_marker;
  logic [CNT_W-1:0]  marker_total;
  logic [BIN_W-1:0]  markers_in_bin;
  logic [CNT_W-1:0]  triple_total;
  logic [CNT_W-1:0]  triples_at_bin_start;
  logic [BIN_W-1:0]  bin_counter;

  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  rec_t              rec_in;
  logic              in_acc;
  logic              take;           // word enters the window
  logic              judge;          // window full after this word
  logic              is_marker;
  logic              is_triple;
  logic              emit;
  logic [BIN_W-1:0]  markers_in_bin_next;
  logic [CNT_W-1:0]  marker_total_next;
  logic [BIN_W-1:0]  bin_counter_next;

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coincidence_window <= WINDOW_RESET;
      markers_per_bin    <= PER_BIN_RESET;
      marker_base        <= BASE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WINDOW:  coincidence_window <= pwdata[WIN_W-1:0];
        REG_PER_BIN: markers_per_bin    <= pwdata[BIN_W-1:0];
        REG_BASE:    marker_base        <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_WINDOW:  prdata = {{(DATA_W-WIN_W){1'b0}}, coincidence_window};
      REG_PER_BIN: prdata = {{(DATA_W-BIN_W){1'b0}}, markers_per_bin};
      REG_BASE:    prdata = marker_base;
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- judge
  // code sits in the low byte of tdata, timestamp above it
  assign rec_in        = rec_t'({s_axis_tdata[CODE_W-1:0],
                                 s_axis_tdata[S_TDATA_W-1:CODE_W]});
  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // before arming, only the first marker-base word gets in
  assign take  = in_acc & (armed | (rec_in.ts == marker_base));
  assign judge = take & (fill == 2'd2);

  // the new word is the third, youngest entry of a full window
  assign is_marker = (win0.ts == expected_marker);
  assign is_triple = ~is_marker & code_ok(win0.code)
                   & near_enough(win1.ts, win0.ts, coincidence_window)
                   & code_ok(win1.code) & (win1.code != win0.code)
                   & near_enough(rec_in.ts, win0.ts, coincidence_window)
                   & code_ok(rec_in.code) & (rec_in.code != win0.code);

  assign markers_in_bin_next = markers_in_bin + 1'b1;
  assign marker_total_next   = marker_total + 1'b1;
  assign bin_counter_next    = bin_counter + 1'b1;
  assign emit = judge & is_marker & (markers_in_bin_next >= markers_per_bin);

  // window: a triple empties it, any other judgement pops one entry
  always_ff @(posedge clk) begin
    if (rst) begin
      armed           <= 1'b0;
      fill            <= 2'd0;
      expected_marker <= BASE_RESET;
    end else if (take) begin
      if (!armed) begin
        armed           <= 1'b1;
        expected_marker <= marker_base;
      end
      priority case (fill)
        2'd0:    fill <= 2'd1;
        2'd1:    fill <= 2'd2;
        default: fill <= is_triple ? 2'd0 : 2'd2;
      endcase
      if (judge && is_marker) begin
        expected_marker <= expected_marker + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      priority case (fill)
        2'd0:    win0 <= rec_in;
        2'd1:    win1 <= rec_in;
        default: begin
          win0 <= win1;
          win1 <= rec_in;
        end
      endcase
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      marker_total         <= '0;
      markers_in_bin       <= '0;
      triple_total         <= '0;
      triples_at_bin_start <= '0;
      bin_counter          <= '0;
    end else if (judge) begin
      if (is_marker) begin
        marker_total <= marker_total_next;
        if (emit) begin
          markers_in_bin       <= '0;
          bin_counter          <= bin_counter_next;
          triples_at_bin_start <= triple_total;
        end else begin
          markers_in_bin <= markers_in_bin_next;
        end
      end else if (is_triple) begin
        triple_total <= triple_total + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {marker_total_next, triple_total,
                       triple_total - triples_at_bin_start, bin_counter_next};
    end
  end

  // ---------------------------------------------------------------- checks
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3) else $error("window fill out of range");

  a_idle_unarmed: assert property (@(posedge clk) disable iff (rst)
    !armed |-> fill == 2'd0) else $error("window filled before arming");

  a_triple_empties: assert property (@(posedge clk) disable iff (rst)
    judge && is_triple |=> fill == 2'd0) else $error("triple left entries");

  a_emit_bin: assert property (@(posedge clk) disable iff (rst)
    emit |=> m_axis_tvalid && markers_in_bin == '0 &&
             bin_counter == $past(bin_counter) + 1'b1)
    else $error("bin close mismatch");

endmodule

// ===== tb/triple_coincidence_counter_tb.sv =====
`timescale 1ns / 1ps

module triple_coincidence_counter_tb;
  import tcc_pkg::*;

  // quiet cycles (no word moved, no APB access) before the run is abandoned
  localparam int QUIET_LIMIT = 4000;
  // cycles allowed after the last expected report before config or the end
  localparam int SETTLE = 4;

  typedef struct packed {
    logic [BIN_W-1:0] bin_index;
    logic [CNT_W-1:0] triples_in_bin;
    logic [CNT_W-1:0] total_triples;
    logic [CNT_W-1:0] total_markers;
  } bin_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  triple_coincidence_counter u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // [7:0] event_code, [39:8] timestamp
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // [15:0] bin_index, [47:16] triples_in_bin, [79:48] total_triples,
    // [111:80] total_markers
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Coincidence predictor: own copy of the config and window state
  // ---------------------------------------------------------------------
  logic [WIN_W-1:0]  cfg_window  = WINDOW_RESET;
  logic [BIN_W-1:0]  cfg_per_bin = PER_BIN_RESET;
  logic [TIME_W-1:0] cfg_base    = BASE_RESET;

  logic              armed = 1'b0;
  logic [CODE_W-1:0] win_code [3];
  logic [TIME_W-1:0] win_ts   [3];
  int unsigned       win_fill = 0;
  logic [TIME_W-1:0] marker_due = BASE_RESET;  // timestamp the next marker must carry
  logic [CNT_W-1:0]  markers_seen = '0;
  logic [CNT_W-1:0]  triples_seen = '0;
  logic [CNT_W-1:0]  triples_at_bin_open = '0;
  logic [BIN_W-1:0]  bin_markers = '0;
  logic [BIN_W-1:0]  bins_done = '0;

  logic [CODE_W-1:0] hit_codes [6] = '{CODE_A, CODE_B, CODE_C, CODE_D, CODE_E, CODE_F};

  rec_t        records_pending [$];  // words still to be offered on s_axis
  bin_report_t reports_due     [$];  // bin reports predicted, not yet seen
  int          mismatches = 0;

  function automatic bit is_hit_code(logic [CODE_W-1:0] c);
    foreach (hit_codes[i])
      if (c == hit_codes[i]) return 1'b1;
    return 1'b0;
  endfunction

  // upper bound only; the sum is one bit wider so it never wraps
  function automatic bit within_reach(logic [TIME_W-1:0] t, logic [TIME_W-1:0] head);
    logic [TIME_W:0] reach;
    reach = {1'b0, head} + {{(TIME_W+1-WIN_W){1'b0}}, cfg_window};
    return {1'b0, t} <= reach;
  endfunction

  task automatic count_record(rec_t r);
    bin_report_t rep;
    bit          is_marker;
    bit          triple;
    if (!armed) begin
      if (r.ts != cfg_base) return;  // dropped before the first marker
      armed = 1'b1;
      marker_due = cfg_base;
    end
    win_code[win_fill] = r.code;
    win_ts[win_fill]   = r.ts;
    win_fill++;
    if (win_fill < 3) return;

    is_marker = (win_ts[0] == marker_due);
    triple = is_hit_code(win_code[0]) &&
             is_hit_code(win_code[1]) && win_code[1] != win_code[0] &&
             is_hit_code(win_code[2]) && win_code[2] != win_code[0] &&
             within_reach(win_ts[1], win_ts[0]) && within_reach(win_ts[2], win_ts[0]);

    if (!is_marker && triple) begin
      // whole window goes, marker timestamps in it included
      triples_seen++;
      win_fill = 0;
    end else begin
      win_code[0] = win_code[1];
      win_ts[0]   = win_ts[1];
      win_code[1] = win_code[2];
      win_ts[1]   = win_ts[2];
      win_fill    = 2;
    end

    if (is_marker) begin
      marker_due++;
      markers_seen++;
      bin_markers++;
      if (bin_markers >= cfg_per_bin) begin
        bin_markers = '0;
        bins_done++;
        rep.bin_index      = bins_done;
        rep.triples_in_bin = triples_seen - triples_at_bin_open;
        rep.total_triples  = triples_seen;
        rep.total_markers  = markers_seen;
        reports_due = {reports_due, rep};
        triples_at_bin_open = triples_seen;
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("%0t mismatch %s: expected %h, got %h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------
  // s_axis driver: takes words from records_pending, random gaps
  // ---------------------------------------------------------------------
  int   send_idle_pct = 0;
  rec_t on_bus;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) count_record(on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (records_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = records_pending.pop_front();
          s_axis_tdata  <= {on_bus.ts, on_bus.code};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // m_axis monitor: random stalls plus an optional long hold-off
  // ---------------------------------------------------------------------
  int recv_stall_pct = 0;
  int recv_hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (reports_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t mismatch: no report was due, got %h", $realtime, m_axis_tdata);
          mismatches++;
        end else begin
          bin_report_t want;
          want = reports_due.pop_front();
          check_field("bin_index",      32'(want.bin_index), 32'(m_axis_tdata[15:0]));
          check_field("triples_in_bin", want.triples_in_bin, m_axis_tdata[47:16]);
          check_field("total_triples",  want.total_triples,  m_axis_tdata[79:48]);
          check_field("total_markers",  want.total_markers,  m_axis_tdata[111:80]);
        end
      end
      if (recv_hold_left > 0) begin
        m_axis_tready  <= 1'b0;
        recv_hold_left <= recv_hold_left - 1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: abandon the run if nothing moves for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("triple_coincidence_counter_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // APB: write, then read back from the same address
  // ---------------------------------------------------------------------
  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register takes the value at this edge
    case (idx)
      REG_WINDOW:  cfg_window  = value[WIN_W-1:0];
      REG_PER_BIN: cfg_per_bin = value[BIN_W-1:0];
      REG_BASE:    cfg_base    = value[TIME_W-1:0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("register readback", value, got);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  logic [TIME_W-1:0] marker_next = BASE_RESET;  // timestamp for the next marker word

  function automatic logic [CODE_W-1:0] other_hit_code(logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] pick;
    pick = hit_codes[$urandom_range(5)];
    while (pick == c) pick = hit_codes[$urandom_range(5)];
    return pick;
  endfunction

  function automatic logic [CODE_W-1:0] junk_code();
    logic [CODE_W-1:0] pick;
    pick = CODE_W'($urandom);
    while (is_hit_code(pick)) pick = CODE_W'($urandom);
    return pick;
  endfunction

  task automatic push(logic [CODE_W-1:0] c, logic [TIME_W-1:0] t);
    rec_t r;
    r.code = c;
    r.ts   = t;
    records_pending = {records_pending, r};
  endtask

  // markers carry an invalid code, so no triple can swallow them
  task automatic push_marker();
    push(junk_code(), marker_next);
    marker_next++;
  endtask

  task automatic push_group(logic [CODE_W-1:0] c0, logic [CODE_W-1:0] c1,
                            logic [CODE_W-1:0] c2, logic [TIME_W-1:0] t0,
                            logic [TIME_W-1:0] t1, logic [TIME_W-1:0] t2);
    push(c0, t0);
    push(c1, t1);
    push(c2, t2);
  endtask

  // mostly markers and candidate triples, some spoilt, some noise
  task automatic queue_random(int n);
    int                pick;
    logic [CODE_W-1:0] c0, c1, c2;
    logic [TIME_W-1:0] t0, t1, t2;
    while (n > 0) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        push_marker();
        n--;
      end else if (pick < 88) begin
        c0 = hit_codes[$urandom_range(5)];
        c1 = other_hit_code(c0);
        c2 = other_hit_code(c0);
        t0 = $urandom;
        t1 = t0 + $urandom_range(0, cfg_window);
        t2 = t0 + $urandom_range(0, cfg_window);
        if ($urandom_range(3) == 0) t1 = t0 - $urandom_range(0, 1000);  // earlier hit is near too
        if (pick >= 70) begin
          case ($urandom_range(4))
            0: c0 = junk_code();
            1: c1 = c0;
            2: c2 = junk_code();
            3: begin
              t0 = $urandom_range(0, 32'hFFFE_0000);
              t2 = t0 + cfg_window + 1 + $urandom_range(0, 500);
            end
            default: begin
              t0 = $urandom_range(0, 32'hFFFE_0000);
              t1 = t0 + cfg_window + 1;
            end
          endcase
        end
        push_group(c0, c1, c2, t0, t1, t2);
        n -= 3;
      end else begin
        push(CODE_W'($urandom), $urandom);
        n--;
      end
    end
  endtask

  // all words taken and every report in; realign the marker sequence
  task automatic wait_idle();
    @(negedge clk);
    while (records_pending.size() != 0 || s_axis_tvalid || reports_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (armed) marker_next = marker_due;
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // widest window, a report on every marker, base set so the marker timestamp wraps
    write_reg(REG_WINDOW,  32'h0000_FFFF);
    write_reg(REG_PER_BIN, 32'd0);
    write_reg(REG_BASE,    32'hFFFF_FFFE);
    marker_next = cfg_base;

    push(8'hFF, 32'h0000_0000);  // ignored, not armed yet
    push(8'h00, 32'hFFFF_FFFF);  // ignored
    push_marker();               // arming word
    // reach runs past 2^32, third hit where a wrapped edge would fall
    push_group(CODE_A, CODE_F, CODE_E, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0000_FFEF);
    push_marker();
    push_marker();               // expected marker wraps to zero
    push_group(CODE_B, CODE_C, CODE_D, 32'd100, 32'd65635, 32'd100);  // at the edge
    push_group(CODE_D, CODE_E, CODE_F, 32'd100, 32'd65636, 32'd100);  // one past
    push_marker();
    push_group(CODE_E, CODE_E, CODE_A, 32'd500, 32'd501, 32'd502);    // repeated code
    push_group(8'd2, CODE_A, CODE_B, 32'd600, 32'd601, 32'd602);      // bad head code
    push_marker();
    // marker word taken as third hit of a triple; same value offered again
    push(CODE_C, marker_next - 5);
    push(CODE_A, marker_next - 4);
    push(CODE_B, marker_next);
    push_marker();
    push(8'hFF, 32'hFFFF_FFFF);
    push(8'h00, 32'h0000_0000);
    wait_idle();

    // bin never closes, closed window; base write while armed changes nothing
    write_reg(REG_PER_BIN, 32'h0000_FFFF);
    write_reg(REG_WINDOW,  32'd0);
    write_reg(REG_BASE,    32'd0);
    queue_random(40);
    wait_idle();

    // bin size lowered mid-bin; sender mostly idle, with a full pause halfway
    write_reg(REG_PER_BIN, 32'd3);
    write_reg(REG_WINDOW,  32'(WINDOW_RESET));
    send_idle_pct = 85;
    queue_random(50);
    wait_idle();
    queue_random(50);
    wait_idle();

    // receiver mostly stalled, long hold-off first so the input backs up
    send_idle_pct = 0;
    write_reg(REG_PER_BIN, 32'd1);
    write_reg(REG_WINDOW,  32'd1000);
    recv_stall_pct = 85;
    @(negedge clk);
    recv_hold_left = 300;
    queue_random(100);
    wait_idle();

    // both sides gappy
    write_reg(REG_PER_BIN, 32'd2);
    write_reg(REG_WINDOW,  32'h0000_FFFF);
    write_reg(REG_BASE,    32'hFFFF_FFFF);
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    queue_random(100);
    wait_idle();

    // flat out, narrow window
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_PER_BIN, 32'd5);
    write_reg(REG_WINDOW,  32'd16);
    queue_random(60);
    wait_idle();

    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("triple_coincidence_counter_tb: done, clean");
    end else begin
      $display("triple_coincidence_counter_tb: done, errors");
    end
    $finish;
  end

endmodule
